### rtl/ffpa_pkg.sv
package ffpa_pkg;

  // Fixed field widths
  localparam int COUNT_W = 9;
  localparam int START_W = 8;
  localparam int FUP_W   = 9;
  localparam int STAT_W  = 2;

  // Request kinds
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    load;      // latch request fields, arm the scan
    logic    clr;       // clearing pass step
    logic    scan;      // scan step
    logic    wr;        // run write step
    logic    res_load;  // load result register
    status_t code;      // status for the result register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_free;   // latched request is a free
    logic bad;       // zero count or run out of range
    logic fup_out;   // first usable page at or beyond the map
    logic hit;       // run found on this scan step
    logic miss;      // last page checked, no run
    logic wr_last;   // final page of the run being written
    logic clr_last;  // final page of the clearing pass
  } sts_t;

endpackage

### rtl/ffpa_if.sv
// Request channel
interface ffpa_req_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [ffpa_pkg::COUNT_W-1:0] page_count;
  logic [ffpa_pkg::START_W-1:0] start_page;

  modport source (output valid, req_type, page_count, start_page, input ready);
  modport sink   (input valid, req_type, page_count, start_page, output ready);
endinterface

// Result channel
interface ffpa_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [ffpa_pkg::STAT_W-1:0]  status;
  logic [ffpa_pkg::START_W-1:0] alloc_start;

  modport source (output valid, status, alloc_start, input ready);
  modport sink   (input valid, status, alloc_start, output ready);
endinterface

// Configuration write channel
interface ffpa_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [ffpa_pkg::FUP_W-1:0] first_usable_page;

  modport source (output valid, first_usable_page, input ready);
  modport sink   (input valid, first_usable_page, output ready);
endinterface

### rtl/ffpa_datapath.sv
module ffpa_datapath #(
  parameter int TOTAL_PAGES = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr,
  input  logic [ffpa_pkg::FUP_W-1:0]   cfg_fup,
  input  logic                         req_type,
  input  logic [ffpa_pkg::COUNT_W-1:0] page_count,
  input  logic [ffpa_pkg::START_W-1:0] start_page,
  input  ffpa_pkg::cmd_t               cmd,
  output ffpa_pkg::sts_t               sts,
  output logic [ffpa_pkg::STAT_W-1:0]  status,
  output logic [ffpa_pkg::START_W-1:0] alloc_start
);

  localparam int PW = (TOTAL_PAGES > 1) ? $clog2(TOTAL_PAGES) : 1;
  localparam int CW = $clog2(TOTAL_PAGES + 1);
  localparam int XW = ((CW > ffpa_pkg::COUNT_W) ? CW : ffpa_pkg::COUNT_W) + 1;
  localparam logic [XW-1:0] TOTAL_X = XW'(TOTAL_PAGES);
  localparam logic [XW-1:0] LAST_X  = XW'(TOTAL_PAGES - 1);
  localparam logic [XW-1:0] ONE_X   = XW'(1);

  // Page map, one used bit per page
  logic mem [TOTAL_PAGES];

  logic          kind;
  logic [XW-1:0] count_x;
  logic [XW-1:0] fup_x;
  logic [XW-1:0] p;
  logic [XW-1:0] chk_page;
  logic          chk_vld;
  logic          rd_bit;
  logic [XW-1:0] run;
  logic [XW-1:0] wptr;
  logic [XW-1:0] wend;
  logic [XW-1:0] found;

  logic [XW-1:0] start_in_x;
  logic [XW-1:0] count_in_x;
  logic [XW-1:0] hit_start;
  logic          hit;
  logic          bad;

  assign start_in_x = XW'(start_page);
  assign count_in_x = XW'(page_count);
  assign hit_start  = chk_page + ONE_X - count_x;

  // Candidate run completes on a free page
  assign hit = cmd.scan && chk_vld && !rd_bit && ((run + ONE_X) == count_x);

  // Range checks on the latched request
  always_comb begin
    bad = (count_x == '0);
    if (kind == ffpa_pkg::REQ_ALLOC) begin
      if (count_x > TOTAL_X) bad = 1'b1;
    end else begin
      if ((wend + ONE_X) > TOTAL_X) bad = 1'b1;
    end
  end

  always_comb begin
    sts.is_free  = (kind == ffpa_pkg::REQ_FREE);
    sts.bad      = bad;
    sts.fup_out  = (fup_x >= TOTAL_X);
    sts.hit      = hit;
    sts.miss     = cmd.scan && chk_vld && !hit && (chk_page == LAST_X);
    sts.wr_last  = (wptr == wend);
    sts.clr_last = (wptr == LAST_X);
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      fup_x <= '0;
    end else if (cfg_wr) begin
      fup_x <= XW'(cfg_fup);
    end
  end

  // Request latch, scan pipeline and write pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr    <= '0;
      chk_vld <= 1'b0;
    end else if (cmd.load) begin
      kind    <= req_type;
      count_x <= count_in_x;
      p       <= fup_x;
      run     <= '0;
      chk_vld <= 1'b0;
      wptr    <= start_in_x;
      wend    <= start_in_x + count_in_x - ONE_X;
      found   <= '0;
    end else if (cmd.clr || cmd.wr) begin
      wptr <= wptr + ONE_X;
    end else if (cmd.scan) begin
      // issue stage
      if (p < TOTAL_X) begin
        chk_page <= p;
        chk_vld  <= 1'b1;
        p        <= p + ONE_X;
      end else begin
        chk_vld <= 1'b0;
      end
      // check stage
      if (chk_vld) begin
        if (rd_bit) begin
          run <= '0;
        end else begin
          run <= run + ONE_X;
        end
      end
      if (hit) begin
        wptr  <= hit_start;
        wend  <= chk_page;
        found <= hit_start;
      end
    end
  end

  // Page map port: one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      mem[wptr[PW-1:0]] <= 1'b0;
    end else if (cmd.wr) begin
      mem[wptr[PW-1:0]] <= ~kind;
    end else if (cmd.scan && (p < TOTAL_X)) begin
      rd_bit <= mem[p[PW-1:0]];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      status <= cmd.code;
      if (cmd.code == ffpa_pkg::ST_OK && kind == ffpa_pkg::REQ_ALLOC) begin
        alloc_start <= found[ffpa_pkg::START_W-1:0];
      end else begin
        alloc_start <= '0;
      end
    end
  end

endmodule

### rtl/ffpa_ctrl.sv
module ffpa_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  input  ffpa_pkg::sts_t sts,
  output ffpa_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_WRITE,
    S_RESULT
  } state_t;

  state_t            state;
  state_t            state_next;
  ffpa_pkg::status_t code;
  ffpa_pkg::status_t code_next;
  logic              rsp_valid_next;
  logic              res_slot_free;

  assign req_ready     = (state == S_IDLE);
  assign res_slot_free = !rsp_valid || rsp_ready;

  // Next state and command decode
  always_comb begin
    state_next   = state;
    code_next    = code;
    cmd          = '0;
    cmd.code     = code;
    case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.bad) begin
          code_next  = ffpa_pkg::ST_INVALID;
          state_next = S_RESULT;
        end else if (sts.is_free) begin
          state_next = S_WRITE;
        end else if (sts.fup_out) begin
          code_next  = ffpa_pkg::ST_NOSPACE;
          state_next = S_RESULT;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit) begin
          state_next = S_WRITE;
        end else if (sts.miss) begin
          code_next  = ffpa_pkg::ST_NOSPACE;
          state_next = S_RESULT;
        end
      end
      S_WRITE: begin
        cmd.wr = 1'b1;
        if (sts.wr_last) begin
          code_next  = ffpa_pkg::ST_OK;
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (res_slot_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Result valid: set on load, cleared on transfer
  always_comb begin
    rsp_valid_next = rsp_valid;
    if (rsp_valid && rsp_ready) rsp_valid_next = 1'b0;
    if (cmd.res_load) rsp_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      code      <= ffpa_pkg::ST_OK;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      code      <= code_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

### rtl/first_fit_page_run_allocator.sv
// First-fit page run allocator. Keeps one used bit per page in a single-port
// page map and serves one request at a time. An allocate scans upward from
// first_usable_page, one page per cycle, for the lowest run of page_count
// free pages, then marks the run used one page per cycle; a free clears its
// run one page per cycle. The single map port reads or writes one page per
// cycle. After reset a clearing pass over every page runs before the first
// request is taken; configuration writes are taken at any time, and must
// only be made while no request is outstanding.
module first_fit_page_run_allocator #(
  parameter int TOTAL_PAGES = 256
) (
  input logic        clk,
  input logic        rst,
  ffpa_req_if.sink   req,
  ffpa_rsp_if.source rsp,
  ffpa_cfg_if.sink   cfg
);

  ffpa_pkg::cmd_t cmd;
  ffpa_pkg::sts_t sts;

  // Register writes are always taken
  assign cfg.ready = 1'b1;

  ffpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ffpa_datapath #(
    .TOTAL_PAGES (TOTAL_PAGES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr      (cfg.valid & cfg.ready),
    .cfg_fup     (cfg.first_usable_page),
    .req_type    (req.req_type),
    .page_count  (req.page_count),
    .start_page  (req.start_page),
    .cmd         (cmd),
    .sts         (sts),
    .status      (rsp.status),
    .alloc_start (rsp.alloc_start)
  );

endmodule
